### design/gekm_pkg.sv
// Shared types, constants and helper functions for the controller event key mapper.
// No dependencies; every other design file but gekm_ram imports this package.
package gekm_pkg;

	localparam int KEY_COUNT    = 32;
	localparam int BUTTON_RULES = 16;
	localparam int AXIS_RULES   = 8;
	localparam int AXIS_COUNT   = 8;

	localparam int BTN_AW = (BUTTON_RULES > 1) ? $clog2(BUTTON_RULES) : 1;
	localparam int AX_AW  = (AXIS_RULES > 1) ? $clog2(AXIS_RULES) : 1;
	localparam int CNT_W  = (BTN_AW > AX_AW) ? BTN_AW : AX_AW;

	// item modes
	localparam logic [1:0] MODE_EVENT  = 2'd0;
	localparam logic [1:0] MODE_BTN_WR = 2'd1;
	localparam logic [1:0] MODE_AX_WR  = 2'd2;

	// configuration register indexes
	localparam logic CFG_CTRL_SEL  = 1'b0;
	localparam logic CFG_ROUTE_MAP = 1'b1;

	localparam logic [15:0] ROUTE_MAP_RST = 16'h4310;

	typedef struct packed {
		logic [1:0]  mode;
		logic [3:0]  rule_slot;
		logic [31:0] filter_bits;
		logic [31:0] match_bits;
		logic [5:0]  key_code;
		logic [2:0]  axis_pick;
		logic        axis_negative;
		logic [14:0] trip_level;
		logic [31:0] button_states;
		logic [63:0] axes_lower;
		logic [63:0] axes_upper;
		logic [3:0]  source_controller;
	} item_t;

	typedef struct packed {
		logic               accepted;
		logic [31:0]        held_keys;
		logic [31:0]        press_edges;
		logic [31:0]        release_edges;
		logic signed [15:0] side_axis;
		logic signed [15:0] forward_axis;
		logic signed [15:0] view_horizontal;
		logic signed [15:0] view_vertical;
	} result_t;

	typedef struct packed {
		logic [31:0] filter;
		logic [31:0] match;
		logic [5:0]  key;
	} btn_rule_t;

	typedef struct packed {
		logic [2:0]  pick;
		logic        neg;
		logic [14:0] trip;
		logic [5:0]  key;
	} axis_rule_t;

	// controller to datapath
	typedef struct packed {
		logic             accept;
		logic             wr_btn;
		logic             wr_axis;
		logic             rsp_plain;
		logic             plain_ok;
		logic             rd_btn;
		logic             rd_axis;
		logic [CNT_W-1:0] rd_idx;
		logic             commit;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic ev_ok;
		logic btn_wr_ok;
		logic axis_wr_ok;
	} status_t;

	function automatic logic [31:0] key_bit(logic [5:0] key);
		logic [31:0] r;
		r = '0;
		if ({26'd0, key} < 32'(KEY_COUNT) && key < 6'd32)
			r[key[4:0]] = 1'b1;
		return r;
	endfunction

	function automatic logic signed [15:0] axis_sel(logic [127:0] axes, logic [2:0] idx);
		logic signed [15:0] v;
		v = '0;
		if ({29'd0, idx} < 32'(AXIS_COUNT))
			v = axes[{idx, 4'd0} +: 16];
		return v;
	endfunction

endpackage

### design/gekm_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module gekm_ram #(
	parameter int W = 8,
	parameter int D = 16,
	parameter int AW = (D > 1) ? $clog2(D) : 1
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [W-1:0]  wdata,
	input  logic [AW-1:0] raddr,
	output logic [W-1:0]  rdata
);

	logic [W-1:0] mem [D];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end

endmodule

### design/gekm_ctrl.sv
// Sequencer for the key mapper: accepts items and walks the rule tables.
// Depends on gekm_pkg.
module gekm_ctrl
	import gekm_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    start,
	input  status_t st,
	output cmd_t    cmd,
	output logic    busy,
	output logic    done
);

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_BWALK  = 3'd1;
	localparam logic [2:0] S_AWALK  = 3'd2;
	localparam logic [2:0] S_DRAIN  = 3'd3;
	localparam logic [2:0] S_COMMIT = 3'd4;

	logic [2:0]       state_q, state_d;
	logic [CNT_W-1:0] cnt_q, cnt_d;
	logic             done_q, done_d;
	logic             take;

	assign busy = (state_q != S_IDLE);
	assign take = start && !busy;
	assign done = done_q;

	always_comb begin
		state_d = state_q;
		cnt_d   = cnt_q;
		done_d  = 1'b0;
		cmd     = '0;
		cmd.rd_idx = cnt_q;
		case (state_q)
			S_IDLE: begin
				if (take) begin
					cmd.accept = 1'b1;
					cnt_d      = '0;
					if (st.ev_ok) begin
						state_d = S_BWALK;
					end else begin
						cmd.wr_btn    = st.btn_wr_ok;
						cmd.wr_axis   = st.axis_wr_ok;
						cmd.rsp_plain = 1'b1;
						cmd.plain_ok  = st.btn_wr_ok || st.axis_wr_ok;
						done_d        = 1'b1;
					end
				end
			end
			S_BWALK: begin
				cmd.rd_btn = 1'b1;
				if (cnt_q == CNT_W'(BUTTON_RULES - 1)) begin
					cnt_d   = '0;
					state_d = S_AWALK;
				end else begin
					cnt_d = cnt_q + 1'b1;
				end
			end
			S_AWALK: begin
				cmd.rd_axis = 1'b1;
				if (cnt_q == CNT_W'(AXIS_RULES - 1))
					state_d = S_DRAIN;
				else
					cnt_d = cnt_q + 1'b1;
			end
			S_DRAIN: begin
				state_d = S_COMMIT;
			end
			S_COMMIT: begin
				cmd.commit = 1'b1;
				done_d     = 1'b1;
				state_d    = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			done_q  <= done_d;
		end
	end

endmodule

### design/gekm_dp.sv
// Datapath: configuration, rule tables, rule evaluation, key state and result register.
// Depends on gekm_pkg and gekm_ram.
module gekm_dp
	import gekm_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  item_t       item,
	input  logic        cfg_we,
	input  logic        cfg_idx,
	input  logic [15:0] cfg_wdata,
	input  cmd_t        cmd,
	output status_t     st,
	output result_t     result
);

	logic [3:0]   ctrl_sel_q;
	logic [15:0]  route_q;
	logic [31:0]  buttons_q;
	logic [127:0] axes_q;
	logic [BUTTON_RULES-1:0] btn_vld_q;
	logic [AXIS_RULES-1:0]   ax_vld_q;
	logic             rd_btn_s1, rd_axis_s1;
	logic [CNT_W-1:0] idx_s1;
	logic [31:0] now_q, held_q;
	logic signed [15:0] remap_q [4];
	logic signed [15:0] remap_d [4];
	result_t res_q;

	btn_rule_t  btn_wr, btn_rd;
	axis_rule_t ax_wr, ax_rd;

	logic [31:0]        btn_hit, ax_hit;
	logic signed [17:0] ax_v, ax_lim;

	// decode
	assign st.ev_ok      = (item.mode == MODE_EVENT) && (item.source_controller == ctrl_sel_q);
	assign st.btn_wr_ok  = (item.mode == MODE_BTN_WR) && ({28'd0, item.rule_slot} < 32'(BUTTON_RULES));
	assign st.axis_wr_ok = (item.mode == MODE_AX_WR) && ({28'd0, item.rule_slot} < 32'(AXIS_RULES));

	assign btn_wr = '{filter: item.filter_bits, match: item.match_bits, key: item.key_code};
	assign ax_wr  = '{pick: item.axis_pick, neg: item.axis_negative,
		trip: item.trip_level, key: item.key_code};

	gekm_ram #(.W($bits(btn_rule_t)), .D(BUTTON_RULES)) u_btn_ram (
		.clk   (clk),
		.we    (cmd.wr_btn),
		.waddr (item.rule_slot[BTN_AW-1:0]),
		.wdata (btn_wr),
		.raddr (cmd.rd_idx[BTN_AW-1:0]),
		.rdata (btn_rd)
	);

	gekm_ram #(.W($bits(axis_rule_t)), .D(AXIS_RULES)) u_ax_ram (
		.clk   (clk),
		.we    (cmd.wr_axis),
		.waddr (item.rule_slot[AX_AW-1:0]),
		.wdata (ax_wr),
		.raddr (cmd.rd_idx[AX_AW-1:0]),
		.rdata (ax_rd)
	);

	// rule evaluation on the entry read last cycle
	always_comb begin
		btn_hit = '0;
		if (btn_vld_q[idx_s1[BTN_AW-1:0]] && ((buttons_q & btn_rd.filter) == btn_rd.match))
			btn_hit = key_bit(btn_rd.key);

		ax_v = 18'(axis_sel(axes_q, ax_rd.pick));
		if (ax_rd.neg)
			ax_v = -ax_v;
		ax_lim = -$signed({3'b000, ax_rd.trip});
		ax_hit = '0;
		if (ax_vld_q[idx_s1[AX_AW-1:0]] && (ax_v < ax_lim))
			ax_hit = key_bit(ax_rd.key);
	end

	// remapped axes, negation saturates
	always_comb begin
		for (int i = 0; i < 4; i++) begin
			remap_d[i] = axis_sel(axes_q, route_q[4*i +: 3]);
			if (route_q[4*i + 3]) begin
				if (remap_d[i] == 16'sh8000)
					remap_d[i] = 16'sh7FFF;
				else
					remap_d[i] = -remap_d[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_sel_q <= '0;
			route_q    <= ROUTE_MAP_RST;
			btn_vld_q  <= '0;
			ax_vld_q   <= '0;
			rd_btn_s1  <= 1'b0;
			rd_axis_s1 <= 1'b0;
			held_q     <= '0;
			for (int i = 0; i < 4; i++)
				remap_q[i] <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_idx)
					CFG_CTRL_SEL:  ctrl_sel_q <= cfg_wdata[3:0];
					CFG_ROUTE_MAP: route_q    <= cfg_wdata;
					default:       route_q    <= route_q;
				endcase
			end
			if (cmd.wr_btn)
				btn_vld_q[item.rule_slot[BTN_AW-1:0]] <= 1'b1;
			if (cmd.wr_axis)
				ax_vld_q[item.rule_slot[AX_AW-1:0]] <= 1'b1;
			rd_btn_s1  <= cmd.rd_btn;
			rd_axis_s1 <= cmd.rd_axis;
			if (cmd.commit) begin
				held_q <= now_q;
				for (int i = 0; i < 4; i++)
					remap_q[i] <= remap_d[i];
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		idx_s1 <= cmd.rd_idx;
		if (cmd.accept) begin
			buttons_q <= item.button_states;
			axes_q    <= {item.axes_upper, item.axes_lower};
			now_q     <= '0;
		end else if (rd_btn_s1) begin
			now_q <= now_q | btn_hit;
		end else if (rd_axis_s1) begin
			now_q <= now_q | ax_hit;
		end
		if (cmd.rsp_plain) begin
			res_q.accepted        <= cmd.plain_ok;
			res_q.held_keys       <= held_q;
			res_q.press_edges     <= '0;
			res_q.release_edges   <= '0;
			res_q.side_axis       <= remap_q[0];
			res_q.forward_axis    <= remap_q[1];
			res_q.view_horizontal <= remap_q[2];
			res_q.view_vertical   <= remap_q[3];
		end else if (cmd.commit) begin
			res_q.accepted        <= 1'b1;
			res_q.held_keys       <= now_q;
			res_q.press_edges     <= now_q & ~held_q;
			res_q.release_edges   <= held_q & ~now_q;
			res_q.side_axis       <= remap_d[0];
			res_q.forward_axis    <= remap_d[1];
			res_q.view_horizontal <= remap_d[2];
			res_q.view_vertical   <= remap_d[3];
		end
	end

	assign result = res_q;

endmodule

### design/gamepad_event_key_mapper_core.sv
// Top level of the controller event key mapper: sequencer plus datapath.
// Depends on gekm_pkg, gekm_ctrl, gekm_dp (and gekm_ram through the datapath).
//
//   channel   | ports                        | transaction
//   ----------+------------------------------+---------------------------------------
//   item in   | start, busy, item            | start high and busy low at a clock edge
//   result    | done, result                 | done high for one cycle, always taken
//   config    | cfg_we, cfg_idx, cfg_wdata   | cfg_we high at a clock edge
//
// Rule writes, rejected events and unused modes: result in the cycle after the
// transaction, busy never rises, so a new item may follow straight away.
// Accepted events: the sequencer walks the
// 16 button rules and then the 8 axis rules through one read port each, one
// entry a cycle, then drains the read register and commits the result.
// busy drops as the result is shown; the next item may be taken in that cycle.
// Reset empties both rule tables at once through per-entry valid flops; no
// clearing pass. The receiver cannot stall results.
module gamepad_event_key_mapper_core
	import gekm_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  item_t       item,
	output logic        done,
	output result_t     result,
	input  logic        cfg_we,
	input  logic        cfg_idx,
	input  logic [15:0] cfg_wdata
);

	cmd_t    cmd;
	status_t st;

	// sequencer: decides per transaction, then steps the table walk
	gekm_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.st     (st),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	// datapath: hold config, rule tables, accumulate the key set, register the result
	gekm_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.item      (item),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata),
		.cmd       (cmd),
		.st        (st),
		.result    (result)
	);

	// every taken item either starts a walk or answers in the next cycle
	a_take_progress: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy || done)
		else $error("taken item neither walking nor answered");

	// a press and a release of the same key cannot both happen
	a_edges_disjoint: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (result.press_edges & result.release_edges) == 32'd0)
		else $error("press and release overlap");

	// a newly pressed key must be held
	a_press_held: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (result.press_edges & ~result.held_keys) == 32'd0)
		else $error("pressed key not held");

	// refused items carry no edges
	a_refused_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		done && !result.accepted |-> result.press_edges == 32'd0
			&& result.release_edges == 32'd0)
		else $error("edges on refused item");

endmodule
